FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the sine voice block.
// Needs nothing else; a synthesis run defines SYNTH to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SVLE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property failed");
`define SVLE_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define SVLE_ASSERT(label, clk, rst_n, prop)
`define SVLE_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: rtl/core/svle_pkg.sv
// Package of the sine voice block: mode codes, envelope and table constants,
// the note increment constants and the quarter-wave sine generator function.
package svle_pkg;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_NOTE_ON  = 2'd1,
        MODE_NOTE_OFF = 2'd2
    } t_mode;

    // The envelope length is a power of two so the gain division is a shift.
    localparam int RAMP_LEN   = 64;
    localparam int RAMP_SHIFT = $clog2(RAMP_LEN);
    localparam int CNT_W      = $clog2(RAMP_LEN + 1);

    localparam int DEF_SINE_TABLE_BITS = 10;
    localparam int DEF_PHASE_BITS      = 32;

    localparam int MAG_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 18;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 18'sd32767;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -18'sd32768;

    // Increments of the top octave (notes 120..131) in cycles per sample * 2^32.
    localparam int SEMIS       = 12;
    localparam int INC_FULL_W  = 48;
    localparam int TOP_OCTAVE  = 10;
    localparam int DIV12_MUL   = 171;
    localparam int DIV12_SHIFT = 11;
    localparam logic [31:0] TOP_INC [SEMIS] = '{
        32'd815363807,  32'd863847862,  32'd915214929,  32'd969636441,
        32'd1027294024, 32'd1088380105, 32'd1153098554, 32'd1221665363,
        32'd1295309365, 32'd1371273005, 32'd1452813141, 32'd1539201906
    };

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // sin(pi/2 * k / 2^qbits) by a Taylor series in Q30, rounded to Q15.
    // Evaluated only at elaboration to build the sine table.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned qbits);
        longint unsigned x;
        longint unsigned term;
        longint unsigned r;
        longint          s;
        int unsigned     i;
        x    = (HALF_PI_Q30 * 64'(k)) >> qbits;
        term = x;
        s    = longint'(x);
        for (i = 1; i <= 7; i++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * i) * (2 * i + 1));
            if (i[0]) begin
                s = s - longint'(term);
            end else begin
                s = s + longint'(term);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        r = (64'(s) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return MAG_W'(r);
    endfunction

endpackage

FILE: rtl/core/svle_if.sv
// Channel interfaces of the sine voice block: the item input and the
// sample output, each with valid/ready handshake. Independent of the package.
interface svle_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [6:0]         note_number;
    logic signed [15:0] mix_in;

    modport source (output valid, output mode, output note_number, output mix_in,
                    input ready);
    modport sink (input valid, input mode, input note_number, input mix_in,
                  output ready);
endinterface

interface svle_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

FILE: rtl/core/svle_sine_rom.sv
// Two-port quarter-wave sine ROM with registered read data.
// Folds a full-wave table index into the quarter table; uses svle_pkg.
module svle_sine_rom #(
    parameter int SINE_TABLE_BITS = svle_pkg::DEF_SINE_TABLE_BITS
) (
    input  logic                       i_clk,
    input  logic [SINE_TABLE_BITS-1:0] i_idx_a,
    input  logic [SINE_TABLE_BITS-1:0] i_idx_b,
    output logic [svle_pkg::MAG_W-1:0] o_mag_a,
    output logic                       o_neg_a,
    output logic [svle_pkg::MAG_W-1:0] o_mag_b,
    output logic                       o_neg_b
);
    import svle_pkg::*;

    localparam int QB   = SINE_TABLE_BITS - 2;
    localparam int QLEN = 1 << QB;

    logic [MAG_W-1:0] w_rom [QLEN+1];
    logic [QB:0]      w_addr_a;
    logic [QB:0]      w_addr_b;
    logic [MAG_W-1:0] r_mag_a;
    logic [MAG_W-1:0] r_mag_b;
    logic             r_neg_a;
    logic             r_neg_b;

    for (genvar g = 0; g <= QLEN; g++) begin : g_rom
        localparam logic [MAG_W-1:0] ENTRY = quarter_sine(g, QB);
        assign w_rom[g] = ENTRY;
    end

    // Odd quarters run the table backwards; the second half is negated.
    assign w_addr_a = i_idx_a[QB] ? ((QB+1)'(QLEN) - {1'b0, i_idx_a[QB-1:0]})
                                  : {1'b0, i_idx_a[QB-1:0]};
    assign w_addr_b = i_idx_b[QB] ? ((QB+1)'(QLEN) - {1'b0, i_idx_b[QB-1:0]})
                                  : {1'b0, i_idx_b[QB-1:0]};

    always_ff @(posedge i_clk) begin
        r_mag_a <= w_rom[w_addr_a];
        r_mag_b <= w_rom[w_addr_b];
        r_neg_a <= i_idx_a[QB+1];
        r_neg_b <= i_idx_b[QB+1];
    end

    assign o_mag_a = r_mag_a;
    assign o_neg_a = r_neg_a;
    assign o_mag_b = r_mag_b;
    assign o_neg_b = r_neg_b;

endmodule

FILE: rtl/core/sine_voice_with_linear_envelope.sv
// Top level of the sine voice block: note and tick input, mixed sample output.
// Depends on svle_pkg, svle_if, svle_sine_rom and assert_macros.svh.
//
// Usage:
// i_item carries one word per event: mode 0 is a sample tick, mode 1 a note
// on for note_number, mode 2 a note off; mode 3 words are taken and dropped.
// Only a tick produces a word on o_result: mix_in plus the sounding voice and
// the release voice, saturated to 16 bits. Note events produce nothing.
// A word is taken in every cycle in which i_item.ready is high, so the block
// sustains one word per cycle. A tick's sample is registered in the output
// or, under a stall, the skid register. The sine of each voice's next phase
// is read from the table in the cycle that state is updated, so a tick needs
// only one multiply per voice, an add and a clamp before the output register.
// A note on starts the voice at phase 0 with a 64-sample linear attack;
// any note event first hands a sounding note to the release voice, which
// fades over 64 samples.
// After reset no note sounds and the release voice is silent. When the
// receiver stalls, one more sample is held in a skid register; i_item.ready
// falls only while that register is full.
`include "assert_macros.svh"

module sine_voice_with_linear_envelope #(
    parameter int SINE_TABLE_BITS = svle_pkg::DEF_SINE_TABLE_BITS,
    parameter int PHASE_BITS      = svle_pkg::DEF_PHASE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svle_in_if.sink     i_item,
    svle_out_if.source  o_result
);
    import svle_pkg::*;

    localparam int SHIFT_BASE = INC_FULL_W - PHASE_BITS;
    localparam int PROD_W     = MAG_W + CNT_W;

    // Voice state.
    logic [PHASE_BITS-1:0] r_cur_phase, n_cur_phase;
    logic [PHASE_BITS-1:0] r_cur_inc, n_cur_inc;
    logic [CNT_W-1:0]      r_att_cnt, n_att_cnt;
    logic                  r_cur_on, n_cur_on;
    logic [PHASE_BITS-1:0] r_rel_phase, n_rel_phase;
    logic [PHASE_BITS-1:0] r_rel_inc, n_rel_inc;
    logic [CNT_W-1:0]      r_rel_cnt, n_rel_cnt;

    // Output register and skid register.
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_skid_valid;
    logic signed [SAMPLE_W-1:0] r_skid_sample;

    logic        w_acc;
    logic        w_push;
    logic        w_pop;
    t_mode       w_mode;

    // Note increment.
    logic [14:0]           w_div_prod;
    logic [3:0]            w_oct;
    logic [6:0]            w_semi_full;
    logic [3:0]            w_semi;
    logic [5:0]            w_shift;
    logic [INC_FULL_W-1:0] w_inc_full;
    logic [PHASE_BITS-1:0] w_note_inc;

    // Voices and mix.
    logic [MAG_W-1:0]          w_cur_mag;
    logic                      w_cur_neg;
    logic [MAG_W-1:0]          w_rel_mag;
    logic                      w_rel_neg;
    logic                      w_rel_active;
    logic [CNT_W-1:0]          w_rel_gain;
    logic [PROD_W-1:0]         w_cur_prod;
    logic [PROD_W-1:0]         w_rel_prod;
    logic signed [SUM_W-1:0]   w_cur_v;
    logic signed [SUM_W-1:0]   w_rel_v;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SAMPLE_W-1:0] w_sample;

    assign w_acc  = i_item.valid && i_item.ready;
    assign w_mode = t_mode'(i_item.mode);
    assign w_push = w_acc && (w_mode == MODE_TICK);
    assign w_pop  = o_result.valid && o_result.ready;

    // Octave and semitone of the note: n / 12 as a multiply by 171 / 2048.
    assign w_div_prod  = 15'(i_item.note_number) * 15'(DIV12_MUL);
    assign w_oct       = w_div_prod[DIV12_SHIFT +: 4];
    assign w_semi_full = i_item.note_number - 7'(w_oct) * 7'(SEMIS);
    assign w_semi      = w_semi_full[3:0];
    assign w_shift     = 6'(TOP_OCTAVE) - 6'(w_oct) + 6'(SHIFT_BASE);
    assign w_inc_full  = {TOP_INC[w_semi], 16'h0000} >> w_shift;
    assign w_note_inc  = w_inc_full[PHASE_BITS-1:0];

    always_comb begin
        n_cur_phase = r_cur_phase;
        n_cur_inc   = r_cur_inc;
        n_att_cnt   = r_att_cnt;
        n_cur_on    = r_cur_on;
        n_rel_phase = r_rel_phase;
        n_rel_inc   = r_rel_inc;
        n_rel_cnt   = r_rel_cnt;
        if (w_acc) begin
            unique case (w_mode)
                MODE_NOTE_ON, MODE_NOTE_OFF: begin
                    // Only a sounding note is handed to the release voice.
                    if (r_cur_on) begin
                        n_rel_phase = r_cur_phase;
                        n_rel_inc   = r_cur_inc;
                        n_rel_cnt   = '0;
                    end
                    if (w_mode == MODE_NOTE_ON) begin
                        n_cur_inc   = w_note_inc;
                        n_cur_phase = '0;
                        n_att_cnt   = '0;
                        n_cur_on    = 1'b1;
                    end else begin
                        n_cur_on = 1'b0;
                    end
                end
                MODE_TICK: begin
                    if (r_cur_on) begin
                        n_cur_phase = r_cur_phase + r_cur_inc;
                        if (r_att_cnt < CNT_W'(RAMP_LEN)) begin
                            n_att_cnt = r_att_cnt + 1'b1;
                        end
                    end
                    if (w_rel_active) begin
                        n_rel_phase = r_rel_phase + r_rel_inc;
                        n_rel_cnt   = r_rel_cnt + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The table is read at the next phases, so its output matches the state.
    svle_sine_rom #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_idx_a (n_cur_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .i_idx_b (n_rel_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .o_mag_a (w_cur_mag),
        .o_neg_a (w_cur_neg),
        .o_mag_b (w_rel_mag),
        .o_neg_b (w_rel_neg)
    );

    assign w_rel_active = r_rel_cnt < CNT_W'(RAMP_LEN);
    assign w_rel_gain   = CNT_W'(RAMP_LEN) - r_rel_cnt;

    // Scaling the magnitude before the sign gives truncation toward zero.
    assign w_cur_prod = PROD_W'(w_cur_mag) * PROD_W'(r_att_cnt);
    assign w_rel_prod = PROD_W'(w_rel_mag) * PROD_W'(w_rel_gain);

    always_comb begin
        w_cur_v = '0;
        w_rel_v = '0;
        if (r_cur_on) begin
            w_cur_v = $signed({{(SUM_W-MAG_W){1'b0}}, w_cur_prod[RAMP_SHIFT +: MAG_W]});
            if (w_cur_neg) begin
                w_cur_v = -w_cur_v;
            end
        end
        if (w_rel_active) begin
            w_rel_v = $signed({{(SUM_W-MAG_W){1'b0}}, w_rel_prod[RAMP_SHIFT +: MAG_W]});
            if (w_rel_neg) begin
                w_rel_v = -w_rel_v;
            end
        end
        w_sum = {{(SUM_W-SAMPLE_W){i_item.mix_in[SAMPLE_W-1]}}, i_item.mix_in}
                + w_cur_v + w_rel_v;
        priority if (w_sum > SUM_MAX) begin
            w_sample = SUM_MAX[SAMPLE_W-1:0];
        end else if (w_sum < SUM_MIN) begin
            w_sample = SUM_MIN[SAMPLE_W-1:0];
        end else begin
            w_sample = w_sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_phase  <= '0;
            r_cur_inc    <= '0;
            r_att_cnt    <= CNT_W'(RAMP_LEN);
            r_cur_on     <= 1'b0;
            r_rel_phase  <= '0;
            r_rel_inc    <= '0;
            r_rel_cnt    <= CNT_W'(RAMP_LEN);
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_cur_phase <= n_cur_phase;
            r_cur_inc   <= n_cur_inc;
            r_att_cnt   <= n_att_cnt;
            r_cur_on    <= n_cur_on;
            r_rel_phase <= n_rel_phase;
            r_rel_inc   <= n_rel_inc;
            r_rel_cnt   <= n_rel_cnt;
            if (w_pop) begin
                if (r_skid_valid) begin
                    r_out_sample <= r_skid_sample;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= w_push;
                    r_out_sample <= w_sample;
                end
            end else if (!r_out_valid) begin
                r_out_valid  <= w_push;
                r_out_sample <= w_sample;
            end else if (w_push) begin
                r_skid_valid  <= 1'b1;
                r_skid_sample <= w_sample;
            end
        end
    end

    assign i_item.ready    = !r_skid_valid;
    assign o_result.valid  = r_out_valid;
    assign o_result.sample = r_out_sample;

    `SVLE_ASSERT_NEVER(a_skid_without_out, i_clk, i_rst_n, r_skid_valid && !r_out_valid)
    `SVLE_ASSERT_NEVER(a_att_cnt_range, i_clk, i_rst_n, r_att_cnt > CNT_W'(RAMP_LEN))
    `SVLE_ASSERT_NEVER(a_rel_cnt_range, i_clk, i_rst_n, r_rel_cnt > CNT_W'(RAMP_LEN))
    `SVLE_ASSERT(a_note_on_starts, i_clk, i_rst_n, (w_acc && w_mode == MODE_NOTE_ON) |=> (r_att_cnt == '0 && r_cur_on))
    `SVLE_ASSERT(a_tick_reaches_out, i_clk, i_rst_n, (w_push && !r_out_valid) |=> r_out_valid)

endmodule
